// ===== rtl/bpe_pkg.sv =====
package bpe_pkg;

  // mode codes
  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_DEBOUNCE = 3'd1;
  localparam logic [2:0] M_PRESSED  = 3'd2;
  localparam logic [2:0] M_REPEAT   = 3'd3;
  localparam logic [2:0] M_RELEASE  = 3'd4;

  // event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PRESS   = 3'd1;
  localparam logic [2:0] EV_LONG    = 3'd2;
  localparam logic [2:0] EV_REPEAT  = 3'd3;
  localparam logic [2:0] EV_RELEASE = 3'd4;

  // configuration register map
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = 2'd3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd100;
  localparam logic [CFG_W-1:0] RELEASE_RST  = 16'd100;

  // payload widths
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned CNT_EXT = 4;

  typedef logic [CODE_W-1:0] mode_t;
  typedef logic [CODE_W-1:0] event_t;
  typedef logic [CFG_W-1:0]  cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

endpackage

// ===== rtl/bpe_if.sv =====
interface bpe_in_if;
  logic                       valid;
  logic                       ready;
  logic                       pin_level;
  logic [bpe_pkg::NOW_W-1:0]  now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bpe_out_if;
  logic                        valid;
  logic                        ready;
  logic [bpe_pkg::CODE_W-1:0]  event_res;
  logic [bpe_pkg::CODE_W-1:0]  mode;
  logic [bpe_pkg::CODE_W-1:0]  release_count;

  modport source (output valid, output event_res, output mode, output release_count,
                  input ready);
  modport sink   (input valid, input event_res, input mode, input release_count,
                  output ready);
endinterface

// ===== rtl/button_press_event_fsm.sv =====
// pushbutton qualifier: debounce, press, long press, auto-repeat and release pulses
// in_ch  : one poll per item (active-low pin level plus millisecond timestamp)
// out_ch : one result item per poll (event code, mode after the poll, release count)
// cfg_*  : write-only register port (debounce, long press, repeat, release limits);
//          write only while no poll is in flight
// latency: result valid one cycle after the accepting edge, so it can be taken at
//          the second edge at the earliest (input register, then the state update
//          and result register)
// throughput: one item per cycle; the whole step is one subtract, one compare and
//          the next-state select between the two registers
// reset: synchronous active-low rst_n clears both stages, returns the machine to
//        idle with timestamp and release count zero and loads default limits
// stall: when out_ch.ready is low the result holds, the input register keeps its
//        item and in_ch.ready drops once that register is full; no item is lost
module button_press_event_fsm #(
  parameter int unsigned RELEASE_PULSES = 6,
  parameter int unsigned TIME_WIDTH     = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bpe_in_if.sink                      in_ch,
  bpe_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  bpe_pkg::cfg_idx_t           cfg_idx,
  input  bpe_pkg::cfg_data_t          cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(RELEASE_PULSES + 1);

  // configuration limits
  bpe_pkg::cfg_data_t debounce_r, long_r, repeat_r, release_r;

  // input stage
  logic                  in_vld_r;
  logic                  in_pin_r;
  logic [TIME_WIDTH-1:0] in_now_r;

  // machine state
  bpe_pkg::mode_t        mode_r, mode_nxt;
  logic [TIME_WIDTH-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  // result stage
  logic                  out_vld_r;
  bpe_pkg::event_t       out_event_r, event_nxt;
  bpe_pkg::mode_t        out_mode_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic [bpe_pkg::CNT_EXT-1:0] out_cnt_ext;

  logic                  advance;
  logic [TIME_WIDTH-1:0] elapsed;
  bpe_pkg::cfg_data_t    limit;
  logic                  over;

  // the held item advances when the result register is empty or being taken
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bpe_pkg::DEBOUNCE_RST;
      long_r     <= bpe_pkg::LONG_RST;
      repeat_r   <= bpe_pkg::REPEAT_RST;
      release_r  <= bpe_pkg::RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bpe_pkg::CFG_DEBOUNCE: debounce_r <= cfg_wdata;
        bpe_pkg::CFG_LONG:     long_r     <= cfg_wdata;
        bpe_pkg::CFG_REPEAT:   repeat_r   <= cfg_wdata;
        bpe_pkg::CFG_RELEASE:  release_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_pin_r <= in_ch.pin_level;
      in_now_r <= in_ch.now_ms[TIME_WIDTH-1:0];
    end
  end

  // elapsed time wraps modulo 2^TIME_WIDTH; the limit follows the current mode
  assign elapsed = in_now_r - tick_r;

  always_comb begin
    unique case (mode_r)
      bpe_pkg::M_DEBOUNCE: limit = debounce_r;
      bpe_pkg::M_PRESSED:  limit = long_r;
      bpe_pkg::M_REPEAT:   limit = repeat_r;
      bpe_pkg::M_RELEASE:  limit = release_r;
      default:             limit = '0;
    endcase
  end

  assign over = elapsed > TIME_WIDTH'(limit);

  // next state for the item in the input register
  always_comb begin
    mode_nxt  = mode_r;
    tick_nxt  = tick_r;
    cnt_nxt   = cnt_r;
    event_nxt = bpe_pkg::EV_NONE;
    unique case (mode_r)
      bpe_pkg::M_DEBOUNCE: begin
        if (over) begin
          if (!in_pin_r) begin
            mode_nxt  = bpe_pkg::M_PRESSED;
            tick_nxt  = in_now_r;
            event_nxt = bpe_pkg::EV_PRESS;
          end else begin
            mode_nxt = bpe_pkg::M_IDLE;
          end
        end
      end
      bpe_pkg::M_PRESSED: begin
        if (in_pin_r) begin
          mode_nxt = bpe_pkg::M_RELEASE;
          cnt_nxt  = '0;
          tick_nxt = in_now_r;
        end else if (over) begin
          mode_nxt  = bpe_pkg::M_REPEAT;
          tick_nxt  = in_now_r;
          event_nxt = bpe_pkg::EV_LONG;
        end
      end
      bpe_pkg::M_REPEAT: begin
        if (in_pin_r) begin
          mode_nxt = bpe_pkg::M_RELEASE;
          cnt_nxt  = '0;
          tick_nxt = in_now_r;
        end else if (over) begin
          tick_nxt  = in_now_r;
          event_nxt = bpe_pkg::EV_REPEAT;
        end
      end
      bpe_pkg::M_RELEASE: begin
        // a new press re-enters debounce measured from the last release stamp
        if (!in_pin_r) begin
          mode_nxt = bpe_pkg::M_DEBOUNCE;
        end else if (over) begin
          if (cnt_r < CNT_W'(RELEASE_PULSES)) begin
            cnt_nxt   = cnt_r + 1'b1;
            tick_nxt  = in_now_r;
            event_nxt = bpe_pkg::EV_RELEASE;
          end else begin
            mode_nxt = bpe_pkg::M_IDLE;
          end
        end
      end
      default: begin
        // idle, and unused codes act as idle
        mode_nxt = bpe_pkg::M_IDLE;
        if (!in_pin_r) begin
          mode_nxt = bpe_pkg::M_DEBOUNCE;
          tick_nxt = in_now_r;
        end
      end
    endcase
  end

  // state and result commit together when the item moves out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= bpe_pkg::M_IDLE;
      tick_r    <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        mode_r <= mode_nxt;
        tick_r <= tick_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r <= event_nxt;
      out_mode_r  <= mode_nxt;
      out_cnt_r   <= cnt_nxt;
    end
  end

  // release count is reported as the counter's low three bits
  assign out_cnt_ext          = bpe_pkg::CNT_EXT'(out_cnt_r);
  assign out_ch.valid         = out_vld_r;
  assign out_ch.event_res     = out_event_r;
  assign out_ch.mode          = out_mode_r;
  assign out_ch.release_count = out_cnt_ext[bpe_pkg::CODE_W-1:0];

  // release counter never runs past the configured pulse count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RELEASE_PULSES))
    else $error("release counter beyond pulse count");

  // a release pulse is only reported in release mode with a nonzero count
  a_rel_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_event_r == bpe_pkg::EV_RELEASE
      |-> out_mode_r == bpe_pkg::M_RELEASE && out_cnt_r != '0)
    else $error("release pulse outside release mode");

  // press and long press land in their own modes
  a_press_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_event_r == bpe_pkg::EV_PRESS |-> out_mode_r == bpe_pkg::M_PRESSED)
    else $error("press event without pressed mode");

  a_long_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_event_r == bpe_pkg::EV_LONG |-> out_mode_r == bpe_pkg::M_REPEAT)
    else $error("long press event without repeat mode");

  // a stalled result freezes the machine state
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> $stable(mode_r) && $stable(tick_r) && $stable(cnt_r))
    else $error("state moved while result stalled");

endmodule
